// ===== rtl/core/doubly_linked_list_cursor_macros.svh =====
// Assertion macros shared by the list engine RTL.
// Depends on nothing; the checks compile away when SYNTHESIS is defined.
`ifndef DOUBLY_LINKED_LIST_CURSOR_MACROS_SVH
`define DOUBLY_LINKED_LIST_CURSOR_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent implies consequent in the same cycle.
`define DLL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("list engine check failed");
// Antecedent implies consequent in the next cycle.
`define DLL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("list engine check failed");
`else
`define DLL_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DLL_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/dll_pkg.sv =====
// Types and constants of the linked list engine: command and status codes,
// request and response structs, deferred write bundle. No dependencies.
`default_nettype none
package dll_pkg;
	localparam int POOL_NODES_DEF = 256;
	localparam int VALUE_BITS_DEF = 32;

	typedef enum logic [4:0] {
		CMD_CLEAR      = 5'd0,
		CMD_INS_FIRST  = 5'd1,
		CMD_INS_LAST   = 5'd2,
		CMD_FIRST      = 5'd3,
		CMD_LAST       = 5'd4,
		CMD_COPY_FIRST = 5'd5,
		CMD_COPY_LAST  = 5'd6,
		CMD_DEL_FIRST  = 5'd7,
		CMD_DEL_LAST   = 5'd8,
		CMD_POST_DEL   = 5'd9,
		CMD_PRE_DEL    = 5'd10,
		CMD_POST_INS   = 5'd11,
		CMD_PRE_INS    = 5'd12,
		CMD_COPY       = 5'd13,
		CMD_UPDATE     = 5'd14,
		CMD_NEXT       = 5'd15,
		CMD_PREV       = 5'd16
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NO_ACTIVE = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef struct packed {
		logic [4:0]         cmd;
		logic signed [31:0] value_in;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value_out;
		logic [1:0]         status;
		logic               is_active;
		logic [8:0]         item_count;
	} rsp_t;

	// Link writes deferred to the second write cycle.
	typedef struct packed {
		logic        nx_en;
		logic [16:0] nx_addr;
		logic [16:0] nx_data;
		logic        pv_en;
		logic [16:0] pv_addr;
		logic [16:0] pv_data;
	} link_wr_t;
endpackage
`default_nettype wire

// ===== rtl/core/doubly_linked_list_cursor.sv =====
// Doubly linked list with a cursor in a fixed node pool. An accepted request passes through
// two read states on the node memories (free list, neighbor link and value), RA and RB,
// two write-back states for links, W1 and W2, then DONE, which moves the result into the
// output register. One request is in flight at a time. The next one is taken as soon as
// the engine is back in idle, even while the last response still waits in the output
// register. The engine holds in its last state, with the input stalled, until that
// response is taken.
// Clear takes effect in one request through head, tail, free list and bump allocator; the
// memories need no clearing pass.
// Uses dll_pkg, dll_ram and doubly_linked_list_cursor_macros.svh.
`default_nettype none
`include "doubly_linked_list_cursor_macros.svh"
module doubly_linked_list_cursor #(
	parameter int POOL_NODES = dll_pkg::POOL_NODES_DEF,
	parameter int VALUE_BITS = dll_pkg::VALUE_BITS_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire dll_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output dll_pkg::rsp_t      rsp
);
	localparam int IDX_BITS = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
	localparam int PTR_BITS = $clog2(POOL_NODES + 1);
	localparam logic [PTR_BITS-1:0] NIL = PTR_BITS'(POOL_NODES);
	localparam logic [PTR_BITS-1:0] ONE = PTR_BITS'(1);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RA   = 6'b000010,
		S_RB   = 6'b000100,
		S_W1   = 6'b001000,
		S_W2   = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q;
	logic [4:0] cmd_q;
	logic signed [31:0] val_q;
	logic [PTR_BITS-1:0] head_q, tail_q, cur_q, free_q, fresh_q, count_q;
	logic [PTR_BITS-1:0] a_next_q, a_prev_q;
	logic [VALUE_BITS-1:0] a_val_q;
	dll_pkg::link_wr_t w2_q, w2_d;
	dll_pkg::rsp_t res_q, res_d;
	dll_pkg::rsp_t rsp_q;
	logic rsp_valid_q;
	logic rsp_load;

	logic [PTR_BITS-1:0] nx_rdata, pv_rdata;
	logic [VALUE_BITS-1:0] vl_rdata;
	logic [PTR_BITS-1:0] nx_raddr, pv_raddr, vl_raddr;

	// first write cycle
	logic vl_we1, nx_we1, pv_we1;
	logic [PTR_BITS-1:0] vl_wa1, nx_wa1, nx_wd1, pv_wa1, pv_wd1;

	logic nx_we, pv_we, vl_we;
	logic [PTR_BITS-1:0] nx_wa, nx_wd, pv_wa, pv_wd;

	logic [PTR_BITS-1:0] d_head, d_tail, d_cur, d_free, d_fresh, d_count;
	logic [PTR_BITS-1:0] n_alloc, free_alloc, fresh_alloc;
	logic alloc_ok;
	logic [PTR_BITS-1:0] p_ptr, q_ptr, count_dec;
	logic [1:0] st_d;
	logic signed [31:0] vout_d;

	logic req_acc;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	// move the result out once the previous response is gone
	assign rsp_load  = (state_q == S_DONE) && !(rsp_valid_q && rsp_stall);

	// read address selection
	always_comb begin
		nx_raddr = NIL;
		pv_raddr = NIL;
		vl_raddr = NIL;
		if (state_q == S_RA) begin
			case (cmd_q) inside
				dll_pkg::CMD_INS_FIRST, dll_pkg::CMD_INS_LAST,
				dll_pkg::CMD_POST_INS, dll_pkg::CMD_PRE_INS: nx_raddr = free_q;
				dll_pkg::CMD_DEL_FIRST:  nx_raddr = head_q;
				dll_pkg::CMD_POST_DEL,
				dll_pkg::CMD_NEXT:       nx_raddr = cur_q;
				dll_pkg::CMD_DEL_LAST:   pv_raddr = tail_q;
				dll_pkg::CMD_PRE_DEL,
				dll_pkg::CMD_PREV:       pv_raddr = cur_q;
				dll_pkg::CMD_COPY_FIRST: vl_raddr = head_q;
				dll_pkg::CMD_COPY_LAST:  vl_raddr = tail_q;
				dll_pkg::CMD_COPY:       vl_raddr = cur_q;
				default: ;
			endcase
		end else if (state_q == S_RB) begin
			case (cmd_q)
				dll_pkg::CMD_POST_DEL: nx_raddr = nx_rdata;
				dll_pkg::CMD_PRE_DEL:  pv_raddr = pv_rdata;
				dll_pkg::CMD_POST_INS: nx_raddr = cur_q;
				dll_pkg::CMD_PRE_INS:  pv_raddr = cur_q;
				default: ;
			endcase
		end
	end

	// allocation from free list, then bump allocator
	always_comb begin
		alloc_ok    = 1'b1;
		n_alloc     = NIL;
		free_alloc  = free_q;
		fresh_alloc = fresh_q;
		if (free_q != NIL) begin
			n_alloc    = free_q;
			free_alloc = a_next_q;
		end else if (fresh_q < NIL) begin
			n_alloc     = fresh_q;
			fresh_alloc = fresh_q + ONE;
		end else begin
			alloc_ok = 1'b0;
		end
	end

	assign count_dec = (count_q != '0) ? count_q - ONE : count_q;

	// command execution in the first write cycle
	always_comb begin
		d_head  = head_q;
		d_tail  = tail_q;
		d_cur   = cur_q;
		d_free  = free_q;
		d_fresh = fresh_q;
		d_count = count_q;
		vl_we1 = 1'b0; vl_wa1 = NIL;
		nx_we1 = 1'b0; nx_wa1 = NIL; nx_wd1 = NIL;
		pv_we1 = 1'b0; pv_wa1 = NIL; pv_wd1 = NIL;
		w2_d   = '0;
		p_ptr  = NIL;
		q_ptr  = NIL;
		st_d   = dll_pkg::ST_OK;
		vout_d = '0;
		unique case (cmd_q)
			dll_pkg::CMD_CLEAR: begin
				d_head = NIL; d_tail = NIL; d_cur = NIL; d_free = NIL;
				d_fresh = '0; d_count = '0;
			end
			dll_pkg::CMD_INS_FIRST: begin
				if (!alloc_ok) begin
					st_d = dll_pkg::ST_FULL;
				end else begin
					d_free = free_alloc; d_fresh = fresh_alloc;
					vl_we1 = 1'b1; vl_wa1 = n_alloc;
					pv_we1 = 1'b1; pv_wa1 = n_alloc; pv_wd1 = NIL;
					nx_we1 = 1'b1; nx_wa1 = n_alloc; nx_wd1 = head_q;
					if (head_q != NIL) begin
						w2_d.pv_en   = 1'b1;
						w2_d.pv_addr = 17'(head_q);
						w2_d.pv_data = 17'(n_alloc);
					end else begin
						d_tail = n_alloc;
					end
					d_head  = n_alloc;
					d_count = count_q + ONE;
				end
			end
			dll_pkg::CMD_INS_LAST: begin
				if (!alloc_ok) begin
					st_d = dll_pkg::ST_FULL;
				end else begin
					d_free = free_alloc; d_fresh = fresh_alloc;
					vl_we1 = 1'b1; vl_wa1 = n_alloc;
					nx_we1 = 1'b1; nx_wa1 = n_alloc; nx_wd1 = NIL;
					pv_we1 = 1'b1; pv_wa1 = n_alloc; pv_wd1 = tail_q;
					if (tail_q != NIL) begin
						w2_d.nx_en   = 1'b1;
						w2_d.nx_addr = 17'(tail_q);
						w2_d.nx_data = 17'(n_alloc);
					end else begin
						d_head = n_alloc;
					end
					d_tail  = n_alloc;
					d_count = count_q + ONE;
				end
			end
			dll_pkg::CMD_FIRST: d_cur = head_q;
			dll_pkg::CMD_LAST:  d_cur = tail_q;
			dll_pkg::CMD_COPY_FIRST: begin
				if (head_q == NIL) st_d = dll_pkg::ST_EMPTY;
				else vout_d = 32'($signed(a_val_q));
			end
			dll_pkg::CMD_COPY_LAST: begin
				if (tail_q == NIL) st_d = dll_pkg::ST_EMPTY;
				else vout_d = 32'($signed(a_val_q));
			end
			dll_pkg::CMD_DEL_FIRST: begin
				if (head_q != NIL) begin
					p_ptr = head_q;
					q_ptr = a_next_q;
					if (cur_q == p_ptr) d_cur = NIL;
					if (tail_q == p_ptr) begin
						d_tail = NIL; d_head = NIL;
					end else begin
						pv_we1 = 1'b1; pv_wa1 = q_ptr; pv_wd1 = NIL;
						d_head = q_ptr;
					end
					nx_we1 = 1'b1; nx_wa1 = p_ptr; nx_wd1 = free_q;
					d_free  = p_ptr;
					d_count = count_dec;
				end
			end
			dll_pkg::CMD_DEL_LAST: begin
				if (tail_q != NIL) begin
					p_ptr = tail_q;
					q_ptr = a_prev_q;
					if (cur_q == p_ptr) d_cur = NIL;
					if (head_q == p_ptr) begin
						d_head = NIL; d_tail = NIL;
					end else begin
						nx_we1 = 1'b1; nx_wa1 = q_ptr; nx_wd1 = NIL;
						d_tail = q_ptr;
					end
					// release link goes second, the next port may be busy
					w2_d.nx_en   = 1'b1;
					w2_d.nx_addr = 17'(p_ptr);
					w2_d.nx_data = 17'(free_q);
					d_free  = p_ptr;
					d_count = count_dec;
				end
			end
			dll_pkg::CMD_POST_DEL: begin
				p_ptr = a_next_q;
				if (cur_q != NIL && cur_q != tail_q && p_ptr != NIL) begin
					if (p_ptr == tail_q) begin
						d_tail = cur_q;
						nx_we1 = 1'b1; nx_wa1 = cur_q; nx_wd1 = NIL;
					end else begin
						q_ptr  = nx_rdata;
						pv_we1 = 1'b1; pv_wa1 = q_ptr; pv_wd1 = cur_q;
						nx_we1 = 1'b1; nx_wa1 = cur_q; nx_wd1 = q_ptr;
					end
					w2_d.nx_en   = 1'b1;
					w2_d.nx_addr = 17'(p_ptr);
					w2_d.nx_data = 17'(free_q);
					d_free  = p_ptr;
					d_count = count_dec;
				end
			end
			dll_pkg::CMD_PRE_DEL: begin
				p_ptr = a_prev_q;
				if (cur_q != NIL && cur_q != head_q && p_ptr != NIL) begin
					if (p_ptr == head_q) begin
						d_head = cur_q;
						pv_we1 = 1'b1; pv_wa1 = cur_q; pv_wd1 = NIL;
					end else begin
						q_ptr  = pv_rdata;
						nx_we1 = 1'b1; nx_wa1 = q_ptr; nx_wd1 = cur_q;
						pv_we1 = 1'b1; pv_wa1 = cur_q; pv_wd1 = q_ptr;
					end
					w2_d.nx_en   = 1'b1;
					w2_d.nx_addr = 17'(p_ptr);
					w2_d.nx_data = 17'(free_q);
					d_free  = p_ptr;
					d_count = count_dec;
				end
			end
			dll_pkg::CMD_POST_INS: begin
				if (cur_q != NIL) begin
					if (!alloc_ok) begin
						st_d = dll_pkg::ST_FULL;
					end else begin
						d_free = free_alloc; d_fresh = fresh_alloc;
						vl_we1 = 1'b1; vl_wa1 = n_alloc;
						q_ptr  = nx_rdata;
						nx_we1 = 1'b1; nx_wa1 = n_alloc;
						if (cur_q == tail_q) begin
							d_tail = n_alloc;
							nx_wd1 = NIL;
						end else begin
							nx_wd1       = q_ptr;
							w2_d.pv_en   = 1'b1;
							w2_d.pv_addr = 17'(q_ptr);
							w2_d.pv_data = 17'(n_alloc);
						end
						pv_we1 = 1'b1; pv_wa1 = n_alloc; pv_wd1 = cur_q;
						w2_d.nx_en   = 1'b1;
						w2_d.nx_addr = 17'(cur_q);
						w2_d.nx_data = 17'(n_alloc);
						d_count = count_q + ONE;
					end
				end
			end
			dll_pkg::CMD_PRE_INS: begin
				if (cur_q != NIL) begin
					if (!alloc_ok) begin
						st_d = dll_pkg::ST_FULL;
					end else begin
						d_free = free_alloc; d_fresh = fresh_alloc;
						vl_we1 = 1'b1; vl_wa1 = n_alloc;
						q_ptr  = pv_rdata;
						pv_we1 = 1'b1; pv_wa1 = n_alloc;
						if (cur_q == head_q) begin
							d_head = n_alloc;
							pv_wd1 = NIL;
						end else begin
							pv_wd1       = q_ptr;
							w2_d.nx_en   = 1'b1;
							w2_d.nx_addr = 17'(q_ptr);
							w2_d.nx_data = 17'(n_alloc);
						end
						nx_we1 = 1'b1; nx_wa1 = n_alloc; nx_wd1 = cur_q;
						w2_d.pv_en   = 1'b1;
						w2_d.pv_addr = 17'(cur_q);
						w2_d.pv_data = 17'(n_alloc);
						d_count = count_q + ONE;
					end
				end
			end
			dll_pkg::CMD_COPY: begin
				if (cur_q == NIL) st_d = dll_pkg::ST_NO_ACTIVE;
				else vout_d = 32'($signed(a_val_q));
			end
			dll_pkg::CMD_UPDATE: begin
				if (cur_q != NIL) begin
					vl_we1 = 1'b1; vl_wa1 = cur_q;
				end
			end
			dll_pkg::CMD_NEXT: if (cur_q != NIL) d_cur = a_next_q;
			dll_pkg::CMD_PREV: if (cur_q != NIL) d_cur = a_prev_q;
			default: ;
		endcase
		res_d.value_out  = vout_d;
		res_d.status     = st_d;
		res_d.is_active  = (d_cur != NIL);
		res_d.item_count = 9'(d_count);
	end

	// write port muxing; never write to the null link
	always_comb begin
		vl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
		nx_wa = nx_wa1; nx_wd = nx_wd1;
		pv_wa = pv_wa1; pv_wd = pv_wd1;
		if (state_q == S_W1) begin
			vl_we = vl_we1 && (vl_wa1 != NIL);
			nx_we = nx_we1 && (nx_wa1 != NIL);
			pv_we = pv_we1 && (pv_wa1 != NIL);
		end else if (state_q == S_W2) begin
			nx_wa = PTR_BITS'(w2_q.nx_addr); nx_wd = PTR_BITS'(w2_q.nx_data);
			pv_wa = PTR_BITS'(w2_q.pv_addr); pv_wd = PTR_BITS'(w2_q.pv_data);
			nx_we = w2_q.nx_en && (nx_wa != NIL);
			pv_we = w2_q.pv_en && (pv_wa != NIL);
		end
	end

	dll_ram #(.WIDTH(VALUE_BITS), .DEPTH(POOL_NODES)) u_val_ram (
		.clk   (clk),
		.we    (vl_we),
		.waddr (vl_wa1[IDX_BITS-1:0]),
		.wdata (VALUE_BITS'(val_q)),
		.raddr (vl_raddr[IDX_BITS-1:0]),
		.rdata (vl_rdata)
	);

	dll_ram #(.WIDTH(PTR_BITS), .DEPTH(POOL_NODES)) u_next_ram (
		.clk   (clk),
		.we    (nx_we),
		.waddr (nx_wa[IDX_BITS-1:0]),
		.wdata (nx_wd),
		.raddr (nx_raddr[IDX_BITS-1:0]),
		.rdata (nx_rdata)
	);

	dll_ram #(.WIDTH(PTR_BITS), .DEPTH(POOL_NODES)) u_prev_ram (
		.clk   (clk),
		.we    (pv_we),
		.waddr (pv_wa[IDX_BITS-1:0]),
		.wdata (pv_wd),
		.raddr (pv_raddr[IDX_BITS-1:0]),
		.rdata (pv_rdata)
	);

	// payload registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			cmd_q <= req.cmd;
			val_q <= req.value_in;
		end
		if (state_q == S_RB) begin
			a_next_q <= nx_rdata;
			a_prev_q <= pv_rdata;
			a_val_q  <= vl_rdata;
		end
		if (state_q == S_W1) begin
			w2_q  <= w2_d;
			res_q <= res_d;
		end
		if (rsp_load)
			rsp_q <= res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= NIL;
			tail_q      <= NIL;
			cur_q       <= NIL;
			free_q      <= NIL;
			fresh_q     <= '0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_acc) state_q <= S_RA;
				S_RA:   state_q <= S_RB;
				S_RB:   state_q <= S_W1;
				S_W1: begin
					head_q  <= d_head;
					tail_q  <= d_tail;
					cur_q   <= d_cur;
					free_q  <= d_free;
					fresh_q <= d_fresh;
					count_q <= d_count;
					state_q <= S_W2;
				end
				S_W2:   state_q <= S_DONE;
				S_DONE: begin
					// hold until the previous response is taken
					if (rsp_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`DLL_ASSERT_IMPL(a_ends_match, clk, arst_n, 1'b1, (head_q == NIL) == (tail_q == NIL))
	`DLL_ASSERT_IMPL(a_cur_needs_nodes, clk, arst_n, cur_q != NIL, count_q != '0)
	`DLL_ASSERT_IMPL(a_count_bound, clk, arst_n, 1'b1, count_q <= NIL)
	`DLL_ASSERT_NEXT(a_accept_starts, clk, arst_n, req_acc, state_q == S_RA)
	`DLL_ASSERT_NEXT(a_rsp_held, clk, arst_n, rsp_valid_q && rsp_stall, rsp_valid_q)
endmodule
`default_nettype wire

// ===== rtl/core/dll_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module dll_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== bench/doubly_linked_list_cursor_tb.sv =====
// Self-checking bench for the linked list engine with a cursor: commands are
// predicted against a behavioral node pool and compared field by field.
// Depends on dll_pkg and the doubly_linked_list_cursor RTL.
`default_nettype none
module doubly_linked_list_cursor_tb;
	localparam int NODES = 256;
	localparam logic [8:0] NIL = 9'd256;
	localparam int CYCLE_LIMIT = 400000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	dll_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	dll_pkg::rsp_t rsp;

	doubly_linked_list_cursor i_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// behavioral list state
	logic [31:0] lst_val [NODES];
	logic [8:0]  lst_next [NODES];
	logic [8:0]  lst_prev [NODES];
	logic [8:0]  lst_head, lst_tail, lst_cur, lst_free, lst_fresh, lst_count;

	dll_pkg::req_t pending_reqs [$];
	dll_pkg::rsp_t expected_rsps [$];
	int   mismatches = 0;
	int   cycles = 0;
	bit   stim_done = 1'b0;
	bit   hold_off = 1'b0;

	function automatic logic [8:0] alloc_node();
		logic [8:0] n;
		if (lst_free != NIL) begin
			n = lst_free;
			lst_free = lst_next[n];
			return n;
		end
		if (lst_fresh < NIL) begin
			n = lst_fresh;
			lst_fresh = lst_fresh + 9'd1;
			return n;
		end
		return NIL;
	endfunction

	function automatic void free_node(logic [8:0] n);
		lst_next[n] = lst_free;
		lst_free = n;
		if (lst_count != 0) lst_count = lst_count - 9'd1;
	endfunction

	function automatic dll_pkg::rsp_t apply_cmd(dll_pkg::req_t r);
		dll_pkg::rsp_t o;
		logic [8:0] n, p, q;
		o = '0;
		o.status = dll_pkg::ST_OK;
		case (r.cmd)
			dll_pkg::CMD_CLEAR: begin
				lst_head = NIL; lst_tail = NIL; lst_cur = NIL; lst_free = NIL;
				lst_fresh = '0; lst_count = '0;
			end
			dll_pkg::CMD_INS_FIRST: begin
				n = alloc_node();
				if (n == NIL) o.status = dll_pkg::ST_FULL;
				else begin
					lst_val[n] = r.value_in; lst_prev[n] = NIL; lst_next[n] = lst_head;
					if (lst_head != NIL) lst_prev[lst_head] = n; else lst_tail = n;
					lst_head = n; lst_count++;
				end
			end
			dll_pkg::CMD_INS_LAST: begin
				n = alloc_node();
				if (n == NIL) o.status = dll_pkg::ST_FULL;
				else begin
					lst_val[n] = r.value_in; lst_next[n] = NIL; lst_prev[n] = lst_tail;
					if (lst_tail != NIL) lst_next[lst_tail] = n; else lst_head = n;
					lst_tail = n; lst_count++;
				end
			end
			dll_pkg::CMD_FIRST: lst_cur = lst_head;
			dll_pkg::CMD_LAST: lst_cur = lst_tail;
			dll_pkg::CMD_COPY_FIRST: begin
				if (lst_head == NIL) o.status = dll_pkg::ST_EMPTY;
				else o.value_out = lst_val[lst_head];
			end
			dll_pkg::CMD_COPY_LAST: begin
				if (lst_tail == NIL) o.status = dll_pkg::ST_EMPTY;
				else o.value_out = lst_val[lst_tail];
			end
			dll_pkg::CMD_DEL_FIRST: if (lst_head != NIL) begin
				p = lst_head;
				if (lst_cur == p) lst_cur = NIL;
				q = lst_next[p];
				if (lst_tail == p) lst_tail = NIL; else lst_prev[q] = NIL;
				lst_head = (lst_tail == NIL) ? NIL : q;
				free_node(p);
			end
			dll_pkg::CMD_DEL_LAST: if (lst_tail != NIL) begin
				p = lst_tail;
				if (lst_cur == p) lst_cur = NIL;
				q = lst_prev[p];
				if (lst_head == p) lst_head = NIL; else lst_next[q] = NIL;
				lst_tail = (lst_head == NIL) ? NIL : q;
				free_node(p);
			end
			dll_pkg::CMD_POST_DEL: if (lst_cur != NIL && lst_cur != lst_tail) begin
				p = lst_next[lst_cur];
				if (p == lst_tail) begin
					lst_tail = lst_cur; lst_next[lst_cur] = NIL;
				end else begin
					q = lst_next[p];
					lst_prev[q] = lst_cur; lst_next[lst_cur] = q;
				end
				free_node(p);
			end
			dll_pkg::CMD_PRE_DEL: if (lst_cur != NIL && lst_cur != lst_head) begin
				p = lst_prev[lst_cur];
				if (p == lst_head) begin
					lst_head = lst_cur; lst_prev[lst_cur] = NIL;
				end else begin
					q = lst_prev[p];
					lst_next[q] = lst_cur; lst_prev[lst_cur] = q;
				end
				free_node(p);
			end
			dll_pkg::CMD_POST_INS: if (lst_cur != NIL) begin
				n = alloc_node();
				if (n == NIL) o.status = dll_pkg::ST_FULL;
				else begin
					lst_val[n] = r.value_in;
					if (lst_cur == lst_tail) begin
						lst_tail = n; lst_next[n] = NIL;
					end else begin
						q = lst_next[lst_cur];
						lst_next[n] = q; lst_prev[q] = n;
					end
					lst_next[lst_cur] = n; lst_prev[n] = lst_cur; lst_count++;
				end
			end
			dll_pkg::CMD_PRE_INS: if (lst_cur != NIL) begin
				n = alloc_node();
				if (n == NIL) o.status = dll_pkg::ST_FULL;
				else begin
					lst_val[n] = r.value_in;
					if (lst_cur == lst_head) begin
						lst_head = n; lst_prev[n] = NIL;
					end else begin
						q = lst_prev[lst_cur];
						lst_prev[n] = q; lst_next[q] = n;
					end
					lst_prev[lst_cur] = n; lst_next[n] = lst_cur; lst_count++;
				end
			end
			dll_pkg::CMD_COPY: begin
				if (lst_cur == NIL) o.status = dll_pkg::ST_NO_ACTIVE;
				else o.value_out = lst_val[lst_cur];
			end
			dll_pkg::CMD_UPDATE: if (lst_cur != NIL) lst_val[lst_cur] = r.value_in;
			dll_pkg::CMD_NEXT: if (lst_cur != NIL) lst_cur = lst_next[lst_cur];
			dll_pkg::CMD_PREV: if (lst_cur != NIL) lst_cur = lst_prev[lst_cur];
			default: ;
		endcase
		o.is_active = (lst_cur != NIL);
		o.item_count = lst_count;
		return o;
	endfunction

	function automatic void queue_cmd(dll_pkg::cmd_t c, logic [31:0] v);
		dll_pkg::req_t r;
		r.cmd = c;
		r.value_in = v;
		pending_reqs.push_back(r);
	endfunction

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// pick a command; grow sets the bias toward inserts
	function automatic dll_pkg::req_t rand_cmd(int grow);
		dll_pkg::req_t r;
		int k;
		k = $urandom_range(0, 99);
		r.value_in = rand_value();
		if (k < grow)
			r.cmd = dll_pkg::cmd_t'($urandom_range(0, 1) ?
				dll_pkg::CMD_INS_LAST : dll_pkg::CMD_INS_FIRST);
		else if (k < grow + 10)
			r.cmd = dll_pkg::cmd_t'($urandom_range(0, 1) ?
				dll_pkg::CMD_POST_INS : dll_pkg::CMD_PRE_INS);
		else if (k == 99)
			r.cmd = $urandom_range(0, 3) == 0 ?
				5'($urandom_range(17, 31)) : dll_pkg::CMD_CLEAR;
		else r.cmd = 5'($urandom_range(1, 16));
		return r;
	endfunction

	initial begin
		int i;
		int grow;
		// directed: empty-list edges, full pool, cursor cases, unknown code
		queue_cmd(dll_pkg::CMD_COPY_FIRST, 0);
		queue_cmd(dll_pkg::CMD_COPY_LAST, 0);
		queue_cmd(dll_pkg::CMD_COPY, 0);
		queue_cmd(dll_pkg::CMD_DEL_FIRST, 0);
		queue_cmd(dll_pkg::CMD_DEL_LAST, 0);
		queue_cmd(dll_pkg::CMD_FIRST, 0);
		queue_cmd(dll_pkg::CMD_POST_INS, 32'h1234);
		queue_cmd(dll_pkg::CMD_NEXT, 0);
		queue_cmd(dll_pkg::CMD_UPDATE, 5);
		queue_cmd(dll_pkg::CMD_INS_LAST, 32'h7fff_ffff);
		queue_cmd(dll_pkg::CMD_INS_FIRST, 32'h8000_0000);
		queue_cmd(dll_pkg::CMD_LAST, 0);
		queue_cmd(dll_pkg::CMD_POST_INS, 32'hffff_ffff);
		queue_cmd(dll_pkg::CMD_PRE_INS, 32'h0);
		queue_cmd(dll_pkg::CMD_COPY, 0);
		queue_cmd(dll_pkg::CMD_PRE_DEL, 0);
		queue_cmd(dll_pkg::CMD_POST_DEL, 0);
		queue_cmd(dll_pkg::CMD_NEXT, 0);
		queue_cmd(dll_pkg::CMD_LAST, 0);
		queue_cmd(dll_pkg::CMD_PREV, 0);
		queue_cmd(dll_pkg::CMD_POST_DEL, 0);
		queue_cmd(dll_pkg::CMD_UPDATE, 32'haaaa_5555);
		queue_cmd(dll_pkg::CMD_COPY_LAST, 0);
		queue_cmd(dll_pkg::cmd_t'(5'd31), 0);
		queue_cmd(dll_pkg::CMD_DEL_LAST, 0);
		// fill pool to overflow, then try every insert flavor
		queue_cmd(dll_pkg::CMD_CLEAR, 0);
		for (i = 0; i < 257; i++) queue_cmd(dll_pkg::CMD_INS_LAST, $urandom);
		queue_cmd(dll_pkg::CMD_INS_FIRST, 1);
		queue_cmd(dll_pkg::CMD_FIRST, 0);
		queue_cmd(dll_pkg::CMD_POST_INS, 2);
		queue_cmd(dll_pkg::CMD_PRE_INS, 3);
		queue_cmd(dll_pkg::CMD_DEL_FIRST, 0);
		queue_cmd(dll_pkg::CMD_PREV, 0);
		queue_cmd(dll_pkg::CMD_PRE_INS, 4);
		queue_cmd(dll_pkg::CMD_INS_LAST, 5);
		queue_cmd(dll_pkg::CMD_CLEAR, 0);
		// random phases with varying growth bias
		for (i = 0; i < 1000; i++) begin
			grow = ((i / 200) % 2) ? 15 : 40;
			pending_reqs.push_back(rand_cmd(grow));
		end
		stim_done = 1'b1;
	end

	// sender: bursts and gaps
	int gap_left = 0;
	int burst_left = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				expected_rsps.push_back(apply_cmd(req));
				void'(pending_reqs.pop_front());
			end
			if (req_valid && req_stall) begin
				// hold the stalled request
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				req_valid <= 1'b0;
			end else if (pending_reqs.size() > ((req_valid && !req_stall) ? 0 : 0)) begin
				if (pending_reqs.size() != 0) begin
					req_valid <= 1'b1;
					req <= pending_reqs[0];
					if (burst_left == 0) begin
						burst_left <= $urandom_range(1, 30);
						if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 8);
					end else burst_left <= burst_left - 1;
				end else req_valid <= 1'b0;
			end else req_valid <= 1'b0;
		end
	end

	// receiver: own stall pattern plus one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (hold_off) rsp_stall <= 1'b1;
			else if (cycles % 1000 < 300) rsp_stall <= 1'b0;
			else rsp_stall <= ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		int k;
		@(posedge arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		for (k = 0; k < 200; k++) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk) begin
		dll_pkg::rsp_t exp_rsp;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_rsps.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %p", rsp);
			end else begin
				exp_rsp = expected_rsps.pop_front();
				if (rsp.value_out !== exp_rsp.value_out || rsp.status !== exp_rsp.status
						|| rsp.is_active !== exp_rsp.is_active
						|| rsp.item_count !== exp_rsp.item_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p actual %p", exp_rsp, rsp);
				end
			end
		end
	end

	initial begin
		lst_head = NIL; lst_tail = NIL; lst_cur = NIL; lst_free = NIL;
		lst_fresh = '0; lst_count = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		wait (stim_done);
		while (pending_reqs.size() != 0 || expected_rsps.size() != 0 || req_valid)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && expected_rsps.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/dll_pkg.sv
rtl/core/dll_ram.sv
rtl/core/doubly_linked_list_cursor.sv
bench/doubly_linked_list_cursor_tb.sv
